[sv/tcf_pkg.sv]
// ----------------------------------------------------------------------------
// tcf_pkg
// shared widths, register indexes, reset values, states and helper functions
// of the tilt filter and incremental pid core
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;

  localparam int RAW_W     = 16;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int ALPHA_W   = 16;
  localparam int DT_W      = 16;
  localparam int RANGE_W   = 11;
  localparam int TGT_W     = 25;

  localparam int STEP_W   = $clog2(CORDIC_STEPS);
  localparam int PRESCALE = 14;
  localparam int CORDIC_W = RAW_W + PRESCALE + 4;
  localparam int ANG_FRAC = 24;
  localparam int Z_W      = ANG_FRAC + 9;
  localparam int ANG_SH   = ANG_FRAC - FRAC_BITS;
  localparam int ANG_RND  = (ANG_SH > 0) ? (1 << (ANG_SH - 1)) : 0;
  localparam int ACC_W    = FRAC_BITS + 9;

  localparam int GAIN_SH = 30;
  localparam logic signed [31:0] INV_GAIN = 32'sd652032874;

  localparam int DIFF_W      = RAW_W + 1;
  localparam int GPROD_W     = DIFF_W + RANGE_W + 1;
  localparam int GYRO_FS_SH  = 15;
  localparam int RATE_WIDE_W = GPROD_W + FRAC_BITS;
  localparam int RATE_W      = GPROD_W + FRAC_BITS - 14;
  localparam int DT_SH       = 16;
  localparam int INCR_W      = RATE_W;
  localparam int SUM_W       = ((INCR_W > OUT_W) ? INCR_W : OUT_W) + 1;

  localparam int ALPHA_SH = 15;
  localparam logic [ALPHA_W:0] ALPHA_ONE = 17'd32768;
  localparam int FUSE_RND = 1 << (ALPHA_SH - 1);

  localparam int MUL_A_PRE = (CORDIC_W > SUM_W) ? CORDIC_W : SUM_W;
  localparam int MUL_A_W   = (MUL_A_PRE > OUT_W) ? MUL_A_PRE : OUT_W;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam int FUSE_W = SUM_W + ALPHA_W + 3;
  localparam int PID_W  = 2 * OUT_W - FRAC_BITS + 3;
  localparam int MAC_W  = (FUSE_W > PID_W) ? FUSE_W : PID_W;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DT         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_NOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV2 = 3'd7;

  localparam logic [ALPHA_W-1:0]        ALPHA_RST      = 16'd31130;
  localparam logic [DT_W-1:0]           DT_RST         = 16'd655;
  localparam logic [RANGE_W-1:0]        RANGE_RST      = 11'd250;
  localparam logic signed [RAW_W-1:0]   OFFSET_RST     = -16'sd601;
  localparam logic signed [TGT_W-1:0]   TARGET_RST     = 25'sd0;
  localparam logic signed [OUT_W-1:0]   COEF_NOW_RST   = 32'sd163840;
  localparam logic signed [OUT_W-1:0]   COEF_PREV_RST  = -32'sd163840;
  localparam logic signed [OUT_W-1:0]   COEF_PREV2_RST = 32'sd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C1_START,
    ST_C1_RUN,
    ST_GAIN,
    ST_C2_RUN,
    ST_RATE,
    ST_INCR,
    ST_FUSE1,
    ST_FUSE2,
    ST_FUSE3,
    ST_ERR,
    ST_PID0,
    ST_PID1,
    ST_PID2,
    ST_PID3,
    ST_OUT
  } state_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = Z_W'(754974720);
      5'd1:  v = Z_W'(445687602);
      5'd2:  v = Z_W'(235489088);
      5'd3:  v = Z_W'(119537938);
      5'd4:  v = Z_W'(60000934);
      5'd5:  v = Z_W'(30029717);
      5'd6:  v = Z_W'(15018523);
      5'd7:  v = Z_W'(7509720);
      5'd8:  v = Z_W'(3754917);
      5'd9:  v = Z_W'(1877466);
      5'd10: v = Z_W'(938734);
      5'd11: v = Z_W'(469367);
      5'd12: v = Z_W'(234684);
      5'd13: v = Z_W'(117342);
      5'd14: v = Z_W'(58671);
      5'd15: v = Z_W'(29335);
      5'd16: v = Z_W'(14668);
      5'd17: v = Z_W'(7334);
      5'd18: v = Z_W'(3667);
      5'd19: v = Z_W'(1833);
      5'd20: v = Z_W'(917);
      5'd21: v = Z_W'(458);
      5'd22: v = Z_W'(229);
      5'd23: v = Z_W'(115);
      5'd24: v = Z_W'(57);
      5'd25: v = Z_W'(29);
      5'd26: v = Z_W'(14);
      5'd27: v = Z_W'(7);
      5'd28: v = Z_W'(4);
      5'd29: v = Z_W'(2);
      5'd30: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp a wide signed value to the 32-bit output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [MAC_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v[MAC_W-1:OUT_W-1] == '0 || v[MAC_W-1:OUT_W-1] == '1) begin
      r = v[OUT_W-1:0];
    end else if (v[MAC_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/tcf_cordic.sv]
// ----------------------------------------------------------------------------
// tcf_cordic
// iterative cordic vectoring unit, one micro-rotation per cycle, angle kept
// in degrees with 24 fraction bits
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_cordic import tcf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [CORDIC_W-1:0] x_init,
  input  logic signed [CORDIC_W-1:0] y_init,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] x_out,
  output logic signed [Z_W-1:0]      z_out
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic                       running;
  logic [STEP_W-1:0]          step;
  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [Z_W-1:0]      z;
  logic signed [CORDIC_W-1:0] x_sh;
  logic signed [CORDIC_W-1:0] y_sh;
  logic signed [Z_W-1:0]      ang;

  assign x_sh  = x >>> step;
  assign y_sh  = y >>> step;
  assign ang   = atan_deg(5'(step));
  assign x_out = x;
  assign z_out = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_init;
      y <= y_init;
      z <= '0;
    end else if (running) begin
      if (!y[CORDIC_W-1]) begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + ang;
      end else begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - ang;
      end
    end
  end

endmodule

`default_nettype wire

[sv/tcf_mul.sv]
// ----------------------------------------------------------------------------
// tcf_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_mul import tcf_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

[sv/tilt_complementary_filter_pid_core.sv]
// ----------------------------------------------------------------------------
// tilt_complementary_filter_pid_core
// accelerometer pitch by cordic, complementary filter with the gyro rate,
// then an incremental pid update of the control value
//
// usage:
//   one request carries accel_x/y/z and gyro_x of a control tick; it is taken
//   when in_valid and in_ready are high at a clock edge. in_ready is high only
//   while the core is idle. each request yields one result (control_value,
//   pitch_angle), taken when out_valid and out_ready are high.
//   when all accelerometer samples are zero the two cordic vectoring passes
//   are skipped. a new request can be taken in the cycle after the result is
//   loaded. the cordic passes run one micro-rotation per cycle; the
//   multiplies go through one shared multiplier in ten further steps.
//   the result sits in an output register; a stalled receiver holds it there
//   and the next request is computed meanwhile, waiting only to load its
//   result until the old one is taken.
//   configuration registers are written through cfg_write/cfg_index/cfg_data;
//   the user must write them only while idle, the core does not enforce it.
//   synchronous reset restores register defaults, clears filter and pid state.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_complementary_filter_pid_core import tcf_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [RAW_W-1:0]     accel_x,
  input  logic signed [RAW_W-1:0]     accel_y,
  input  logic signed [RAW_W-1:0]     accel_z,
  input  logic signed [RAW_W-1:0]     gyro_x,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_W-1:0]     control_value,
  output logic signed [OUT_W-1:0]     pitch_angle,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  state_t state;
  state_t state_next;

  // configuration
  logic [ALPHA_W-1:0]        alpha_q15;
  logic [DT_W-1:0]           dt_q16;
  logic [RANGE_W-1:0]        gyro_range_dps;
  logic signed [RAW_W-1:0]   gyro_offset_raw;
  logic signed [TGT_W-1:0]   target_pitch;
  logic signed [OUT_W-1:0]   coef_now;
  logic signed [OUT_W-1:0]   coef_prev;
  logic signed [OUT_W-1:0]   coef_prev2;

  // filter and pid state
  logic signed [OUT_W-1:0]   pitch_est;
  logic signed [OUT_W-1:0]   err_last;
  logic signed [OUT_W-1:0]   err_before_last;
  logic signed [OUT_W-1:0]   control_acc;

  // request and work registers
  logic signed [RAW_W-1:0]   ax;
  logic signed [RAW_W-1:0]   ay;
  logic signed [RAW_W-1:0]   az;
  logic signed [RAW_W-1:0]   gx;
  logic signed [ACC_W-1:0]   acc_ang;
  logic signed [MAC_W-1:0]   mac_acc;
  logic signed [OUT_W-1:0]   err_cur;

  // sequencer outputs
  logic                      req_take;
  logic                      cord_start;
  logic signed [CORDIC_W-1:0] cord_x_init;
  logic signed [CORDIC_W-1:0] cord_y_init;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      ang_load;
  logic                      mac_set_fuse;
  logic                      mac_set_pid;
  logic                      mac_add_pid;
  logic                      pitch_load;
  logic                      err_load;
  logic                      out_load;

  // shared units
  logic                       cord_done;
  logic signed [CORDIC_W-1:0] cord_x;
  logic signed [Z_W-1:0]      cord_z;
  logic signed [PROD_W-1:0]   prod;

  // derived values
  logic                       accel_zero;
  logic signed [CORDIC_W-1:0] az_ext;
  logic signed [CORDIC_W-1:0] az_abs;
  logic signed [CORDIC_W-1:0] gain_mag;
  logic signed [DIFF_W-1:0]   gyro_diff;
  logic signed [RATE_WIDE_W-1:0] rate_wide;
  logic signed [RATE_W-1:0]   rate;
  logic signed [INCR_W-1:0]   incr;
  logic signed [SUM_W-1:0]    fuse_sum;
  logic [ALPHA_W:0]           alpha_eff;
  logic [ALPHA_W:0]           alpha_rest;
  logic signed [MAC_W-1:0]    fuse_total;
  logic signed [MAC_W-1:0]    err_diff;
  logic signed [MAC_W-1:0]    pid_term;
  logic signed [MAC_W-1:0]    ctrl_sum;
  logic signed [ACC_W-1:0]    acc_ang_new;

  assign accel_zero = (accel_x == '0) && (accel_y == '0) && (accel_z == '0);
  assign az_ext     = CORDIC_W'(az);
  assign az_abs     = az_ext[CORDIC_W-1] ? -az_ext : az_ext;
  assign gain_mag   = CORDIC_W'(prod >>> GAIN_SH);
  assign gyro_diff  = DIFF_W'(gx) - DIFF_W'(gyro_offset_raw);
  assign rate_wide  = RATE_WIDE_W'($signed(prod[GPROD_W-1:0])) <<< FRAC_BITS;
  assign rate       = RATE_W'(rate_wide >>> GYRO_FS_SH);
  assign incr       = INCR_W'(prod >>> DT_SH);
  assign fuse_sum   = SUM_W'(pitch_est) + SUM_W'(incr);
  assign alpha_eff  = ({1'b0, alpha_q15} > ALPHA_ONE) ? ALPHA_ONE : {1'b0, alpha_q15};
  assign alpha_rest = ALPHA_ONE - alpha_eff;
  assign fuse_total = mac_acc + MAC_W'(prod) + MAC_W'(FUSE_RND);
  assign err_diff   = MAC_W'(target_pitch) - MAC_W'(pitch_est);
  assign pid_term   = MAC_W'(prod >>> FRAC_BITS);
  assign ctrl_sum   = MAC_W'(control_acc) + mac_acc;
  assign acc_ang_new = ACC_W'((cord_z + Z_W'(ANG_RND)) >>> ANG_SH);

  tcf_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cord_start),
    .x_init (cord_x_init),
    .y_init (cord_y_init),
    .done   (cord_done),
    .x_out  (cord_x),
    .z_out  (cord_z)
  );

  tcf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = accel_zero ? ST_RATE : ST_C1_START;
        end
      end
      ST_C1_START: state_next = ST_C1_RUN;
      ST_C1_RUN: begin
        if (cord_done) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN: state_next = ST_C2_RUN;
      ST_C2_RUN: begin
        if (cord_done) begin
          state_next = ST_RATE;
        end
      end
      ST_RATE:  state_next = ST_INCR;
      ST_INCR:  state_next = ST_FUSE1;
      ST_FUSE1: state_next = ST_FUSE2;
      ST_FUSE2: state_next = ST_FUSE3;
      ST_FUSE3: state_next = ST_ERR;
      ST_ERR:   state_next = ST_PID0;
      ST_PID0:  state_next = ST_PID1;
      ST_PID1:  state_next = ST_PID2;
      ST_PID2:  state_next = ST_PID3;
      ST_PID3:  state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready     = 1'b0;
    req_take     = 1'b0;
    cord_start   = 1'b0;
    cord_x_init  = '0;
    cord_y_init  = '0;
    mul_a        = '0;
    mul_b        = '0;
    ang_load     = 1'b0;
    mac_set_fuse = 1'b0;
    mac_set_pid  = 1'b0;
    mac_add_pid  = 1'b0;
    pitch_load   = 1'b0;
    err_load     = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        req_take = in_valid;
      end
      ST_C1_START: begin
        cord_start  = 1'b1;
        cord_x_init = az_abs <<< PRESCALE;
        cord_y_init = CORDIC_W'(ay) <<< PRESCALE;
      end
      ST_C1_RUN: begin
        mul_a = MUL_A_W'(cord_x);
        mul_b = INV_GAIN;
      end
      ST_GAIN: begin
        cord_start  = 1'b1;
        cord_x_init = gain_mag;
        cord_y_init = CORDIC_W'(ax) <<< PRESCALE;
      end
      ST_C2_RUN: begin
        ang_load = cord_done;
      end
      ST_RATE: begin
        mul_a = MUL_A_W'(gyro_diff);
        mul_b = MUL_B_W'($signed({1'b0, gyro_range_dps}));
      end
      ST_INCR: begin
        mul_a = MUL_A_W'(rate);
        mul_b = MUL_B_W'($signed({1'b0, dt_q16}));
      end
      ST_FUSE1: begin
        mul_a = MUL_A_W'(fuse_sum);
        mul_b = MUL_B_W'($signed({1'b0, alpha_eff}));
      end
      ST_FUSE2: begin
        mac_set_fuse = 1'b1;
        mul_a        = MUL_A_W'(acc_ang);
        mul_b        = MUL_B_W'($signed({1'b0, alpha_rest}));
      end
      ST_FUSE3: begin
        pitch_load = 1'b1;
      end
      ST_ERR: begin
        err_load = 1'b1;
      end
      ST_PID0: begin
        mul_a = MUL_A_W'(err_cur);
        mul_b = coef_now;
      end
      ST_PID1: begin
        mac_set_pid = 1'b1;
        mul_a       = MUL_A_W'(err_last);
        mul_b       = coef_prev;
      end
      ST_PID2: begin
        mac_add_pid = 1'b1;
        mul_a       = MUL_A_W'(err_before_last);
        mul_b       = coef_prev2;
      end
      ST_PID3: begin
        mac_add_pid = 1'b1;
      end
      ST_OUT: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q15       <= ALPHA_RST;
      dt_q16          <= DT_RST;
      gyro_range_dps  <= RANGE_RST;
      gyro_offset_raw <= OFFSET_RST;
      target_pitch    <= TARGET_RST;
      coef_now        <= COEF_NOW_RST;
      coef_prev       <= COEF_PREV_RST;
      coef_prev2      <= COEF_PREV2_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ALPHA:      alpha_q15       <= cfg_data[ALPHA_W-1:0];
        REG_DT:         dt_q16          <= cfg_data[DT_W-1:0];
        REG_RANGE:      gyro_range_dps  <= cfg_data[RANGE_W-1:0];
        REG_OFFSET:     gyro_offset_raw <= $signed(cfg_data[RAW_W-1:0]);
        REG_TARGET:     target_pitch    <= $signed(cfg_data[TGT_W-1:0]);
        REG_COEF_NOW:   coef_now        <= $signed(cfg_data[OUT_W-1:0]);
        REG_COEF_PREV:  coef_prev       <= $signed(cfg_data[OUT_W-1:0]);
        REG_COEF_PREV2: coef_prev2      <= $signed(cfg_data[OUT_W-1:0]);
        default: ;
      endcase
    end
  end

  // filter and pid state, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_est       <= '0;
      err_last        <= '0;
      err_before_last <= '0;
      control_acc     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pitch_load) begin
        pitch_est <= sat_out(fuse_total >>> ALPHA_SH);
      end
      if (out_load) begin
        control_acc     <= sat_out(ctrl_sum);
        err_before_last <= err_last;
        err_last        <= err_cur;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // work and output registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      ax      <= accel_x;
      ay      <= accel_y;
      az      <= accel_z;
      gx      <= gyro_x;
      acc_ang <= '0;
    end else if (ang_load) begin
      acc_ang <= acc_ang_new;
    end
    if (mac_set_fuse) begin
      mac_acc <= MAC_W'(prod);
    end else if (mac_set_pid) begin
      mac_acc <= pid_term;
    end else if (mac_add_pid) begin
      mac_acc <= mac_acc + pid_term;
    end
    if (err_load) begin
      err_cur <= sat_out(err_diff);
    end
    if (out_load) begin
      control_value <= sat_out(ctrl_sum);
      pitch_angle   <= pitch_est;
    end
  end

endmodule

`default_nettype wire

[sv/tcf_checker.sv]
// ----------------------------------------------------------------------------
// tcf_checker
// port-level checks of the tilt filter and pid core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_checker import tcf_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] control_value,
  input logic signed [OUT_W-1:0] pitch_angle
);

  // busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("core ready in the cycle after taking a request");

  // a new result appears exactly as the core returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && !$past(in_ready))
    else $error("result raised outside the return to idle");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(control_value)
      && $stable(pitch_angle))
    else $error("stalled result changed or dropped");

  // reset leaves the core idle and empty
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("core not idle after reset");

endmodule

bind tilt_complementary_filter_pid_core tcf_checker u_tcf_checker (.*);

`default_nettype wire

[bench/tilt_complementary_filter_pid_core_tb.sv]
// ----------------------------------------------------------------------------
// tilt_complementary_filter_pid_core_tb
// self-checking bench for the tilt filter and pid core: sensor requests go in
// bursts with random gaps, the result side stalls on its own pattern and twice
// holds off long enough to back the core up; every result is checked against
// a fixed point model of the cordic pitch, the fusion and the pid update
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_complementary_filter_pid_core_tb;
  import tcf_pkg::*;

  localparam int ANGLE_SH = 24 - FRAC_BITS;

  typedef struct packed {
    logic signed [RAW_W-1:0] ax;
    logic signed [RAW_W-1:0] ay;
    logic signed [RAW_W-1:0] az;
    logic signed [RAW_W-1:0] gx;
  } sensor_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] control_value;
    logic signed [OUT_W-1:0] pitch_angle;
  } tick_out_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]      alpha;
    logic [DT_W-1:0]         dt;
    logic [RANGE_W-1:0]      fs_dps;
    logic signed [RAW_W-1:0] offset;
    logic signed [TGT_W-1:0] target;
    logic signed [OUT_W-1:0] cnow;
    logic signed [OUT_W-1:0] cprev;
    logic signed [OUT_W-1:0] cprev2;
  } settings_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [RAW_W-1:0] accel_x = '0;
  logic signed [RAW_W-1:0] accel_y = '0;
  logic signed [RAW_W-1:0] accel_z = '0;
  logic signed [RAW_W-1:0] gyro_x = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] control_value;
  logic signed [OUT_W-1:0] pitch_angle;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  tilt_complementary_filter_pid_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .gyro_x        (gyro_x),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .control_value (control_value),
    .pitch_angle   (pitch_angle),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // model copy of the registers and of the filter/pid state
  logic [ALPHA_W-1:0]      m_alpha  = 16'd31130;
  logic [DT_W-1:0]         m_dt     = 16'd655;
  logic [RANGE_W-1:0]      m_fs_dps = 11'd250;
  logic signed [RAW_W-1:0] m_offset = -16'sd601;
  logic signed [TGT_W-1:0] m_target = '0;
  logic signed [OUT_W-1:0] m_cnow   = 32'sd163840;
  logic signed [OUT_W-1:0] m_cprev  = -32'sd163840;
  logic signed [OUT_W-1:0] m_cprev2 = '0;
  logic signed [OUT_W-1:0] m_pitch  = '0;
  logic signed [OUT_W-1:0] m_err1   = '0;
  logic signed [OUT_W-1:0] m_err2   = '0;
  logic signed [OUT_W-1:0] m_ctrl   = '0;

  // atan(2^-i) in degrees, 24 fraction bits
  longint atan_q24 [0:31] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
    7, 4, 2, 1, 0
  };

  sensor_req_t sensor_reqs[$];
  tick_out_t   predicted_outputs[$];
  sensor_req_t next_req;
  sensor_req_t taken_req;
  tick_out_t   want;

  int       reqs_offered = 0;
  int       reqs_taken = 0;
  int       outputs_seen = 0;
  int       bad_outputs = 0;
  int       gap_left = 0;
  int       burst_left = 0;
  int       rx_left = 0;
  int       rx_run = 0;
  logic     rx_level = 1'b1;
  logic     rdy;
  rx_mode_t rx_mode = RX_OPEN;
  logic     hold_off = 1'b0;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint accel_tilt_deg(input longint ax, input longint ay,
                                            input longint az);
    longint x, y, z, t;
    int i;
    z = 0;
    if (ax == 0 && ay == 0 && az == 0) return 0;
    x = (az < 0 ? -az : az) * 16384;
    y = ay * 16384;
    for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
      end
    end
    x = (x * 64'sd652032874) >>> 30;
    y = ax * 16384;
    for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + atan_q24[i];
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - atan_q24[i];
      end
    end
    if (ANGLE_SH > 0) z = (z + (64'sd1 <<< (ANGLE_SH - 1))) >>> ANGLE_SH;
    return z;
  endfunction

  function automatic tick_out_t advance_filter_pid(input sensor_req_t r);
    longint acc, rate, incr, a, f, pitch, e, sum, ctrl;
    tick_out_t o;
    acc  = accel_tilt_deg(longint'(r.ax), longint'(r.ay), longint'(r.az));
    rate = ((longint'(r.gx) - longint'(m_offset)) * longint'(m_fs_dps)
            * (64'sd1 <<< FRAC_BITS)) >>> 15;
    incr = (rate * longint'(m_dt)) >>> 16;
    a    = (m_alpha > 16'd32768) ? 64'sd32768 : longint'(m_alpha);
    f    = a * (longint'(m_pitch) + incr) + (64'sd32768 - a) * acc;
    pitch = clip32((f + 64'sd16384) >>> 15);
    e    = clip32(longint'(m_target) - pitch);
    sum  = ((longint'(m_cnow) * e) >>> FRAC_BITS)
         + ((longint'(m_cprev) * longint'(m_err1)) >>> FRAC_BITS)
         + ((longint'(m_cprev2) * longint'(m_err2)) >>> FRAC_BITS);
    ctrl = clip32(longint'(m_ctrl) + sum);
    m_pitch = pitch[OUT_W-1:0];
    m_err2  = m_err1;
    m_err1  = e[OUT_W-1:0];
    m_ctrl  = ctrl[OUT_W-1:0];
    o.control_value = m_ctrl;
    o.pitch_angle   = m_pitch;
    return o;
  endfunction

  function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] d);
    case (idx)
      REG_ALPHA:      m_alpha  = d[ALPHA_W-1:0];
      REG_DT:         m_dt     = d[DT_W-1:0];
      REG_RANGE:      m_fs_dps = d[RANGE_W-1:0];
      REG_OFFSET:     m_offset = d[RAW_W-1:0];
      REG_TARGET:     m_target = d[TGT_W-1:0];
      REG_COEF_NOW:   m_cnow   = d[OUT_W-1:0];
      REG_COEF_PREV:  m_cprev  = d[OUT_W-1:0];
      REG_COEF_PREV2: m_cprev2 = d[OUT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [RAW_W-1:0] corner_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'sh0001;
      4: return 16'shFFFF;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic sensor_req_t random_req();
    sensor_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.ax = RAW_W'($urandom);
    r.ay = RAW_W'($urandom);
    r.az = RAW_W'($urandom);
    r.gx = RAW_W'($urandom);
    if (pick < 40) begin
      // robot near upright, gravity mostly on z
      r.ax = RAW_W'($urandom_range(0, 16000) - 8000);
      r.ay = RAW_W'($urandom_range(0, 4000) - 2000);
      r.az = RAW_W'($urandom_range(10000, 17000));
      if ($urandom_range(0, 3) == 0) r.az = -r.az;
      r.gx = RAW_W'($urandom_range(0, 4000) - 2601);
    end else if (pick < 60) begin
      r.ax = corner_sample();
      r.ay = corner_sample();
      r.az = corner_sample();
      r.gx = corner_sample();
    end else if (pick < 70) begin
      r.ax = '0;
      r.ay = '0;
      r.az = '0;
    end
    return r;
  endfunction

  function automatic settings_t random_settings(input logic wild);
    settings_t s;
    if (wild) begin
      s.alpha  = ALPHA_W'($urandom);
      s.dt     = DT_W'($urandom);
      s.fs_dps = RANGE_W'($urandom);
      s.offset = RAW_W'($urandom);
      s.target = TGT_W'($urandom);
      s.cnow   = $urandom;
      s.cprev  = $urandom;
      s.cprev2 = $urandom;
    end else begin
      s.alpha  = ALPHA_W'($urandom_range(29000, 32768));
      s.dt     = DT_W'($urandom_range(100, 3000));
      s.fs_dps = 11'd250 << $urandom_range(0, 3);
      s.offset = RAW_W'($urandom_range(0, 2000) - 1000);
      s.target = TGT_W'($urandom_range(0, 3932160) - 1966080);
      s.cnow   = $urandom_range(0, 600000);
      s.cprev  = -$urandom_range(0, 600000);
      s.cprev2 = $urandom_range(0, 100000) - 50000;
    end
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    store_setting(idx, value);
  endtask

  // upper bits of the data word carry junk the core must ignore
  task automatic apply_settings(input settings_t s);
    write_reg(REG_ALPHA, {16'($urandom), s.alpha});
    write_reg(REG_DT, {16'($urandom), s.dt});
    write_reg(REG_RANGE, {21'($urandom), s.fs_dps});
    write_reg(REG_OFFSET, {16'($urandom), s.offset});
    write_reg(REG_TARGET, {7'($urandom), s.target});
    write_reg(REG_COEF_NOW, s.cnow);
    write_reg(REG_COEF_PREV, s.cprev);
    write_reg(REG_COEF_PREV2, s.cprev2);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_req(input logic signed [RAW_W-1:0] ax, input logic signed [RAW_W-1:0] ay,
                           input logic signed [RAW_W-1:0] az, input logic signed [RAW_W-1:0] gx);
    sensor_req_t r;
    r.ax = ax;
    r.ay = ay;
    r.az = az;
    r.gx = gx;
    sensor_reqs.push_back(r);
  endtask

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++) sensor_reqs.push_back(random_req());
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (sensor_reqs.size() != 0 || reqs_taken != reqs_offered ||
           predicted_outputs.size() != 0 || !in_ready)
      @(negedge clk);
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (reqs_taken == reqs_offered) begin
      if (gap_left > 0 || sensor_reqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
        accel_x  <= RAW_W'($urandom);
        accel_y  <= RAW_W'($urandom);
        accel_z  <= RAW_W'($urandom);
        gyro_x   <= RAW_W'($urandom);
      end else begin
        next_req = sensor_reqs.pop_front();
        in_valid <= 1'b1;
        accel_x  <= next_req.ax;
        accel_y  <= next_req.ay;
        accel_z  <= next_req.az;
        gyro_x   <= next_req.gx;
        reqs_offered++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 7);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
        end
      end
    end
  end

  // result side stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 150);
    end else begin
      rx_left--;
    end
    if (rx_run == 0) begin
      rx_run   = $urandom_range(1, 60);
      rx_level = ~rx_level;
    end else begin
      rx_run--;
    end
    case (rx_mode)
      RX_OPEN:   rdy = 1'b1;
      RX_COIN:   rdy = 1'($urandom_range(0, 1));
      RX_SPARSE: rdy = ($urandom_range(0, 7) == 0);
      default:   rdy = rx_level;
    endcase
    out_ready <= rdy && !hold_off && !rst;
  end

  // long hold-offs so the core fills up and stops taking requests
  initial begin
    wait (outputs_seen >= 40);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
    wait (outputs_seen >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (250) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        taken_req.ax = accel_x;
        taken_req.ay = accel_y;
        taken_req.az = accel_z;
        taken_req.gx = gyro_x;
        predicted_outputs.push_back(advance_filter_pid(taken_req));
        reqs_taken++;
      end
      if (out_valid && out_ready) begin
        if (predicted_outputs.size() == 0) begin
          bad_outputs++;
          if (bad_outputs <= 10)
            $display("unexpected result: control_value %0d pitch_angle %0d",
                     control_value, pitch_angle);
        end else begin
          want = predicted_outputs.pop_front();
          if (control_value !== want.control_value || pitch_angle !== want.pitch_angle) begin
            bad_outputs++;
            if (bad_outputs <= 10)
              $display("result %0d: control_value exp %0d got %0d, pitch_angle exp %0d got %0d",
                       outputs_seen, want.control_value, control_value,
                       want.pitch_angle, pitch_angle);
          end
        end
        outputs_seen++;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL tilt_complementary_filter_pid_core");
    $finish;
  end

  initial begin
    settings_t s;
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults
    queue_req(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_req(16'sh0000, 16'sh0000, 16'sh0000, -16'sd601);
    queue_req(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_req(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_req(16'sd16384, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_req(-16'sd16384, 16'sh0000, 16'sh0000, 16'sd100);
    queue_req(16'sh0000, 16'sh0000, 16'sd16384, 16'sh0000);
    queue_req(16'sh0000, 16'sh0000, -16'sd16384, 16'sh0000);
    queue_req(16'sh0000, 16'sd16384, 16'sh0000, 16'sh0000);
    queue_req(16'sh0000, -16'sd16384, 16'sh0000, 16'sh0000);
    queue_req(16'sd11585, 16'sh0000, 16'sd11585, -16'sd601);
    queue_req(16'sh8000, 16'sh0000, 16'shFFFF, 16'sd5);
    queue_req(16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001);
    queue_req(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
    queue_req(16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    queue_req(16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh8000);
    queue_random(60);
    wait_quiet();

    // accelerometer only, widest gyro terms, extreme pid weights
    s = '{alpha: 16'h0000, dt: 16'hFFFF, fs_dps: 11'h7FF, offset: 16'sh7FFF,
          target: 25'sh0FFFFFF, cnow: 32'sh7FFFFFFF, cprev: 32'sh80000000,
          cprev2: 32'sh7FFFFFFF};
    apply_settings(s);
    queue_random(40);
    wait_quiet();

    // alpha above one, gyro drives pitch to positive saturation
    s = '{alpha: 16'hFFFF, dt: 16'hFFFF, fs_dps: 11'd2000, offset: 16'sh8000,
          target: 25'sh1000000, cnow: 32'shFFFFFFFF, cprev: 32'sh00000001,
          cprev2: 32'sh80000000};
    apply_settings(s);
    queue_random(40);
    wait_quiet();

    // gyro only, pitch driven to negative saturation
    s = '{alpha: 16'd32768, dt: 16'hFFFF, fs_dps: 11'h7FF, offset: 16'sh7FFF,
          target: 25'sd0, cnow: 32'sd163840, cprev: -32'sd163840, cprev2: 32'sd65536};
    apply_settings(s);
    queue_random(40);
    wait_quiet();

    // no gyro motion at all
    s = '{alpha: 16'd20000, dt: 16'd0, fs_dps: 11'd0, offset: 16'sd0,
          target: 25'sd11796480, cnow: 32'sd65536, cprev: 32'sd0, cprev2: -32'sd32768};
    apply_settings(s);
    queue_random(30);
    wait_quiet();

    for (n = 0; n < 5; n++) begin
      apply_settings(random_settings(n % 2 == 0));
      queue_random(60);
      wait_quiet();
    end

    repeat (60) @(posedge clk);
    if (bad_outputs == 0 && predicted_outputs.size() == 0)
      $display("PASS tilt_complementary_filter_pid_core");
    else
      $display("FAIL tilt_complementary_filter_pid_core");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
sv/tcf_pkg.sv
sv/tcf_cordic.sv
sv/tcf_mul.sv
sv/tilt_complementary_filter_pid_core.sv
sv/tcf_checker.sv
bench/tilt_complementary_filter_pid_core_tb.sv
